// File: hw/rtl/msa_pkg.sv
// shared types and constants for the spare allocator
`default_nettype none
package msa_pkg;

    localparam logic [1:0] MODE_FAULT   = 2'd0;
    localparam logic [1:0] MODE_WL_MARK = 2'd1;
    localparam logic [1:0] MODE_BL_MARK = 2'd2;

    localparam logic [2:0] ST_MARKED    = 3'd0;
    localparam logic [2:0] ST_BL_ALLOC  = 3'd1;
    localparam logic [2:0] ST_BL_COVERS = 3'd2;
    localparam logic [2:0] ST_WL_ALLOC  = 3'd3;
    localparam logic [2:0] ST_WL_COVERS = 3'd4;
    localparam logic [2:0] ST_NO_SPARE  = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;
    localparam logic [2:0] ST_IGNORED   = 3'd7;

    localparam int unsigned WINDOW_MASK = 32'h7FF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BL_RD,
        S_BL_EV,
        S_WL_RD,
        S_WL_EV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic simple;
        logic bl_init;
        logic bl_eval;
        logic bl_next;
        logic wl_init;
        logic wl_eval;
        logic wl_next;
        logic fail;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_repair;
        logic bl_hit;
        logic bl_last;
        logic wl_hit;
        logic wl_last;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

// File: hw/rtl/msa_ctrl.sv
// sequencing state machine for the spare search
`default_nettype none
module msa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire msa_pkg::t_stat i_stat,
    output msa_pkg::t_cmd      o_cmd
);
    import msa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = i_stat.is_repair ? S_BL_RD : S_DONE;
            S_BL_RD:  n_state = S_BL_EV;
            S_BL_EV: begin
                if (i_stat.bl_hit) n_state = S_DONE;
                else if (i_stat.bl_last) n_state = S_WL_RD;
                else n_state = S_BL_RD;
            end
            S_WL_RD:  n_state = S_WL_EV;
            S_WL_EV: begin
                if (i_stat.wl_hit || i_stat.wl_last) n_state = S_DONE;
                else n_state = S_WL_RD;
            end
            S_DONE:   if (!i_stat.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.simple  = !i_stat.is_repair;
                o_cmd.bl_init = i_stat.is_repair;
            end
            S_BL_EV: begin
                o_cmd.bl_eval = 1'b1;
                o_cmd.wl_init = !i_stat.bl_hit && i_stat.bl_last;
                o_cmd.bl_next = !i_stat.bl_hit && !i_stat.bl_last;
            end
            S_WL_EV: begin
                o_cmd.wl_eval = 1'b1;
                o_cmd.fail    = !i_stat.wl_hit && i_stat.wl_last;
                o_cmd.wl_next = !i_stat.wl_hit && !i_stat.wl_last;
            end
            S_DONE:   o_cmd.emit = !i_stat.out_busy;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: hw/rtl/msa_dp.sv
// spare tables, scan counters and result registers
`default_nettype none
module msa_dp #(
    parameter int unsigned BL_SPARES_PER_MAT = 4,
    parameter int unsigned SMALL_MATS        = 24,
    parameter int unsigned BIG_MATS          = 8,
    parameter int unsigned WL_SPARES_PER_MAT = 16,
    parameter int unsigned BIG_MAT_ROWS      = 2048,
    parameter int unsigned SMALL_MAT_ROWS    = 688
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_mode,
    input  wire logic [13:0]   i_row,
    input  wire logic [6:0]    i_col,
    input  wire msa_pkg::t_cmd i_cmd,
    output msa_pkg::t_stat     o_stat,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_status,
    output logic [6:0]         o_spare_index,
    output logic               o_repair_failed
);
    import msa_pkg::*;

    localparam int unsigned BLD  = BL_SPARES_PER_MAT * SMALL_MATS;
    localparam int unsigned WLD  = BIG_MATS * WL_SPARES_PER_MAT;
    localparam int unsigned BLAW = (BLD > 1) ? $clog2(BLD) : 1;
    localparam int unsigned WLAW = (WLD > 1) ? $clog2(WLD) : 1;
    localparam int unsigned IW   = (BL_SPARES_PER_MAT > 1) ? $clog2(BL_SPARES_PER_MAT) : 1;
    localparam int unsigned BW   = (BIG_MATS > 1) ? $clog2(BIG_MATS) : 1;
    localparam int unsigned SW   = (WL_SPARES_PER_MAT > 1) ? $clog2(WL_SPARES_PER_MAT) : 1;
    localparam logic [15:0] SUB2_START = 16'(2 * SMALL_MAT_ROWS - 16);

    // latched word
    logic [1:0]  r_mode;
    logic [13:0] r_row;
    logic [6:0]  r_col;

    // one valid flag per entry, reset clears them at once
    logic [BLD-1:0] r_bl_vld;
    logic [WLD-1:0] r_wl_vld;
    logic [8:0]     r_bl_mem [BLD];   // faulty, used, column
    logic [15:0]    r_wl_mem [WLD];   // faulty, used, row
    logic [8:0]     r_bl_q;
    logic [15:0]    r_wl_q;
    logic           r_failed;

    logic [BLAW-1:0] r_bl_k;
    logic [IW-1:0]   r_i;
    logic [BW-1:0]   r_b, r_j;
    logic [SW-1:0]   r_s;

    logic [2:0]  r_res_status;
    logic [15:0] r_res_idx;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [6:0]  r_out_idx;
    logic        r_out_failed;

    // locate big and small mat
    logic [10:0] off;
    logic [1:0]  sub;
    logic [4:0]  big;
    logic [15:0] sml_mat;
    logic        in_range;
    logic [BW-1:0] b_first;
    logic [WLAW-1:0] wl_k;
    logic [15:0] bl_mark_k;

    always_comb begin
        off = r_row[10:0] & 11'(WINDOW_MASK);
        sub = 2'd0;
        if (16'(off) >= 16'(SMALL_MAT_ROWS)) begin
            sub = (16'(off) >= SUB2_START) ? 2'd2 : 2'd1;
        end
        // big mat by threshold compares, saturates at BIG_MATS when out of range
        big = '0;
        for (int unsigned k = 1; k <= BIG_MATS; k++) begin
            if (32'(r_row) >= k * BIG_MAT_ROWS) big = big + 5'd1;
        end
        sml_mat  = 16'(big) * 16'd3 + 16'(sub);
        in_range = (32'(big) < BIG_MATS) && (32'(sml_mat) < SMALL_MATS);
        b_first  = (32'(big) == BIG_MATS - 1) ? '0 : BW'(big) + BW'(1);
        wl_k     = WLAW'(32'(r_b) * WL_SPARES_PER_MAT + 32'(r_s));
        bl_mark_k = 16'(32'(r_col) * SMALL_MATS) + sml_mat;
    end

    logic bl_faulty, bl_used, bl_covers, wl_faulty, wl_used, wl_covers;
    logic bl_alloc, bl_mark, wl_alloc, wl_mark;
    always_comb begin
        bl_faulty = r_bl_vld[r_bl_k] && r_bl_q[8];
        bl_used   = r_bl_vld[r_bl_k] && r_bl_q[7];
        bl_covers = bl_used && (r_bl_q[6:0] == r_col);
        wl_faulty = r_wl_vld[wl_k] && r_wl_q[15];
        wl_used   = r_wl_vld[wl_k] && r_wl_q[14];
        wl_covers = wl_used && (r_wl_q[13:0] == r_row);
        o_stat.is_repair = (r_mode == MODE_FAULT) && !r_failed && in_range;
        o_stat.bl_hit  = !bl_faulty && (!bl_used || bl_covers);
        o_stat.bl_last = (32'(r_i) == BL_SPARES_PER_MAT - 1);
        o_stat.wl_hit  = !wl_faulty && (!wl_used || wl_covers);
        o_stat.wl_last = (32'(r_s) == WL_SPARES_PER_MAT - 1) && (32'(r_j) == BIG_MATS - 1);
        o_stat.out_busy = r_out_valid && !i_out_ready;
        bl_alloc = i_cmd.bl_eval && o_stat.bl_hit && !bl_used;
        wl_alloc = i_cmd.wl_eval && o_stat.wl_hit && !wl_used;
        bl_mark  = i_cmd.simple && (r_mode == MODE_BL_MARK) && in_range
                   && (32'(r_col) < BL_SPARES_PER_MAT);
        wl_mark  = i_cmd.simple && (r_mode == MODE_WL_MARK) && (32'(r_row) < WLD);
    end

    // memory arrays with registered reads
    always_ff @(posedge i_clk) begin
        if (bl_alloc) begin
            r_bl_mem[r_bl_k] <= {1'b0, 1'b1, r_col};
        end else if (bl_mark) begin
            r_bl_mem[BLAW'(bl_mark_k)] <= {1'b1, 1'b0, 7'd0};
        end
        r_bl_q <= r_bl_mem[r_bl_k];
    end

    always_ff @(posedge i_clk) begin
        if (wl_alloc) begin
            r_wl_mem[wl_k] <= {1'b0, 1'b1, r_row};
        end else if (wl_mark) begin
            r_wl_mem[WLAW'(r_row)] <= {1'b1, 1'b0, 14'd0};
        end
        r_wl_q <= r_wl_mem[wl_k];
    end

    // valid flags, sticky failure and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl_vld    <= '0;
            r_wl_vld    <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (bl_alloc) begin
                r_bl_vld[r_bl_k] <= 1'b1;
            end else if (bl_mark) begin
                r_bl_vld[BLAW'(bl_mark_k)] <= 1'b1;
            end
            if (wl_alloc) begin
                r_wl_vld[wl_k] <= 1'b1;
            end else if (wl_mark) begin
                r_wl_vld[WLAW'(r_row)] <= 1'b1;
            end
            if (i_cmd.fail) r_failed <= 1'b1;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload: latched word, counters, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_row  <= i_row;
            r_col  <= i_col;
        end
        if (i_cmd.bl_init) begin
            r_bl_k <= BLAW'(sml_mat);
            r_i    <= '0;
        end else if (i_cmd.bl_next) begin
            r_bl_k <= r_bl_k + BLAW'(SMALL_MATS);
            r_i    <= r_i + IW'(1);
        end
        if (i_cmd.wl_init) begin
            r_b <= b_first;
            r_j <= BW'(1);
            r_s <= '0;
        end else if (i_cmd.wl_next) begin
            if (32'(r_s) == WL_SPARES_PER_MAT - 1) begin
                r_s <= '0;
                r_j <= r_j + BW'(1);
                r_b <= (32'(r_b) == BIG_MATS - 1) ? '0 : r_b + BW'(1);
            end else begin
                r_s <= r_s + SW'(1);
            end
        end
        if (i_cmd.simple) begin
            priority if (r_mode == MODE_WL_MARK) begin
                if (32'(r_row) < WLD) begin
                    r_res_status <= ST_MARKED;
                    r_res_idx    <= 16'(r_row);
                end else begin
                    r_res_status <= ST_RANGE;
                    r_res_idx    <= '0;
                end
            end else if (r_mode == MODE_BL_MARK) begin
                if (in_range && 32'(r_col) < BL_SPARES_PER_MAT) begin
                    r_res_status <= ST_MARKED;
                    r_res_idx    <= bl_mark_k;
                end else begin
                    r_res_status <= ST_RANGE;
                    r_res_idx    <= '0;
                end
            end else if (r_mode == MODE_FAULT && !r_failed) begin
                r_res_status <= ST_RANGE;
                r_res_idx    <= '0;
            end else begin
                r_res_status <= ST_IGNORED;
                r_res_idx    <= '0;
            end
        end
        if (i_cmd.bl_eval && o_stat.bl_hit) begin
            r_res_status <= bl_covers ? ST_BL_COVERS : ST_BL_ALLOC;
            r_res_idx    <= 16'(r_bl_k);
        end
        if (i_cmd.wl_eval && o_stat.wl_hit) begin
            r_res_status <= wl_covers ? ST_WL_COVERS : ST_WL_ALLOC;
            r_res_idx    <= 16'(wl_k);
        end
        if (i_cmd.fail) begin
            r_res_status <= ST_NO_SPARE;
            r_res_idx    <= '0;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx[6:0];
            r_out_failed <= r_failed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_spare_index   = r_out_idx;
    assign o_repair_failed = r_out_failed;
endmodule
`default_nettype wire

// File: hw/rtl/memory_spare_allocator_unit.sv
// top level of the memory spare allocator
`default_nettype none
// result: a spare mark or a rejected word is registered through S_DECODE and S_DONE; a fault
//   also scans bitline spares of its small mat, then wordline spares of the other big mats
// flow: one word at a time, the next word taken the cycle after the result is registered,
//   which waits in S_DONE while the output is busy; each spare entry is read, then evaluated
// reset: synchronous active low, clears entry valid flags, failure flag, output valid, state
module memory_spare_allocator_unit #(
    parameter int unsigned BL_SPARES_PER_MAT = 4,
    parameter int unsigned SMALL_MATS        = 24,
    parameter int unsigned BIG_MATS          = 8,
    parameter int unsigned WL_SPARES_PER_MAT = 16,
    parameter int unsigned BIG_MAT_ROWS      = 2048,
    parameter int unsigned SMALL_MAT_ROWS    = 688
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // mode[1:0], row_addr[15:2], col_addr[22:16]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata   // status[2:0], spare_index[9:3], repair_failed[10]
);
    import msa_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [2:0] status;
    logic [6:0] spare_index;
    logic       repair_failed;

    // controller walks the scan one entry at a time
    msa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath holds the spare tables and the output register
    msa_dp #(
        .BL_SPARES_PER_MAT (BL_SPARES_PER_MAT),
        .SMALL_MATS        (SMALL_MATS),
        .BIG_MATS          (BIG_MATS),
        .WL_SPARES_PER_MAT (WL_SPARES_PER_MAT),
        .BIG_MAT_ROWS      (BIG_MAT_ROWS),
        .SMALL_MAT_ROWS    (SMALL_MAT_ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_s_axis_tdata[1:0]),
        .i_row           (i_s_axis_tdata[15:2]),
        .i_col           (i_s_axis_tdata[22:16]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_status        (status),
        .o_spare_index   (spare_index),
        .o_repair_failed (repair_failed)
    );

    // result word packed from the lowest bit up, zero padded
    assign o_m_axis_tdata = {5'd0, repair_failed, spare_index, status};
endmodule
`default_nettype wire
